// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the contact core checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nppc_pkg.sv =====
`default_nettype none
package nppc_pkg;

    localparam int CW       = 32;
    localparam int DW       = CW + 2;
    localparam int VW       = CW + 1;
    localparam int AW       = 31;
    localparam int SQW      = 2 * AW + 2;
    localparam int LW       = SQW / 2;
    localparam int NormBits = 30;
    localparam int QW       = NormBits + 1;
    localparam int NW       = QW + 1;
    localparam int NUMW     = AW + NormBits + 1;
    localparam int DVW      = NUMW + 1;
    localparam int OW       = 48;
    localparam int GW       = 32;
    localparam int PW       = 32;
    localparam int FracBits = 16;
    localparam int XW       = 72;

    localparam int PairI [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PairJ [6] = '{0, 1, 2, 1, 2, 2};

    typedef enum logic [2:0] {
        RegPenalty  = 3'd0,
        RegTangent  = 3'd1,
        RegFixedEn  = 3'd2,
        RegNormalX  = 3'd3,
        RegNormalY  = 3'd4,
        RegNormalZ  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] master_x;
        logic signed [CW-1:0] master_y;
        logic signed [CW-1:0] master_z;
        logic signed [CW-1:0] slave_x;
        logic signed [CW-1:0] slave_y;
        logic signed [CW-1:0] slave_z;
        logic signed [CW-1:0] master_ux;
        logic signed [CW-1:0] master_uy;
        logic signed [CW-1:0] master_uz;
        logic signed [CW-1:0] slave_ux;
        logic signed [CW-1:0] slave_uy;
        logic signed [CW-1:0] slave_uz;
    } in_item_t;

    typedef struct packed {
        logic signed [OW-1:0] force_x;
        logic signed [OW-1:0] force_y;
        logic signed [OW-1:0] force_z;
        logic signed [OW-1:0] stiff_xx;
        logic signed [OW-1:0] stiff_xy;
        logic signed [OW-1:0] stiff_xz;
        logic signed [OW-1:0] stiff_yy;
        logic signed [OW-1:0] stiff_yz;
        logic signed [OW-1:0] stiff_zz;
        logic signed [GW-1:0] gap;
        logic                 normal_error;
    } out_item_t;

    typedef struct packed {
        logic [PW-1:0]        penalty;
        logic                 tangent_enable;
        logic                 fixed_normal_enable;
        logic signed [CW-1:0] fixed_normal_x;
        logic signed [CW-1:0] fixed_normal_y;
        logic signed [CW-1:0] fixed_normal_z;
    } cfg_t;

    typedef struct packed {
        logic [2:0][DW-1:0] d;
        logic [2:0]         neg;
        logic               err;
    } side_t;

    function automatic logic signed [XW-1:0] rnd_shr(input logic signed [XW-1:0] x,
                                                     input int s);
        logic signed [XW-1:0] bias;
        bias = XW'(1) <<< (s - 1);
        return (x + bias) >>> s;
    endfunction

    function automatic logic signed [OW-1:0] sat_ow(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (XW'(1) <<< (OW - 1)) - XW'(1);
        lo = -hi - XW'(1);
        if (x > hi)
            return hi[OW-1:0];
        else if (x < lo)
            return lo[OW-1:0];
        return x[OW-1:0];
    endfunction

    function automatic logic signed [GW-1:0] sat_gw(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (XW'(1) <<< (GW - 1)) - XW'(1);
        lo = -hi - XW'(1);
        if (x > hi)
            return hi[GW-1:0];
        else if (x < lo)
            return lo[GW-1:0];
        return x[GW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/node_pair_penalty_contact_core.sv =====
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_item  (node pair, Q15.16)
// out      output     out_valid/out_stall out_item (forces, stiffness, gap, flag)
// cfg      input      cfg_write          cfg_index, cfg_data
//
// one node pair enters per cycle while out is not stalled
// the longest parts of the pipe are the 32 stage square root and the 31 stage divider
// rst_n clears all valid bits and loads the register defaults
// a held result on out stalls the whole pipe, in_stall follows at once
`default_nettype none
module node_pair_penalty_contact_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire nppc_pkg::in_item_t      in_item,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output nppc_pkg::out_item_t          out_item,
    input  wire logic                    cfg_write,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [nppc_pkg::PW-1:0] cfg_data
);
    import nppc_pkg::*;

    cfg_t               cfg_reg;
    logic               adv;

    logic               n_vld;
    logic [SQW-1:0]     n_sum;
    logic [2:0][AW-1:0] n_a;
    side_t              n_side;

    logic               s_vld;
    logic [LW-1:0]      s_root;
    logic [2:0][AW-1:0] s_a;
    side_t              s_side;

    logic               d_vld;
    logic [2:0][QW-1:0] d_quot;
    side_t              d_side;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{penalty: PW'(1) << FracBits, default: 0};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                RegPenalty: cfg_reg.penalty             <= cfg_data;
                RegTangent: cfg_reg.tangent_enable      <= cfg_data[0];
                RegFixedEn: cfg_reg.fixed_normal_enable <= cfg_data[0];
                RegNormalX: cfg_reg.fixed_normal_x      <= $signed(cfg_data);
                RegNormalY: cfg_reg.fixed_normal_y      <= $signed(cfg_data);
                RegNormalZ: cfg_reg.fixed_normal_z      <= $signed(cfg_data);
                default:    cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    nppc_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (in_valid),
        .item     (in_item),
        .cfg      (cfg_reg),
        .vld_out  (n_vld),
        .sum_sq   (n_sum),
        .a_out    (n_a),
        .side_out (n_side)
    );

    nppc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (n_vld),
        .sum_sq   (n_sum),
        .a_in     (n_a),
        .side_in  (n_side),
        .vld_out  (s_vld),
        .root     (s_root),
        .a_out    (s_a),
        .side_out (s_side)
    );

    nppc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (s_vld),
        .root     (s_root),
        .a_in     (s_a),
        .side_in  (s_side),
        .vld_out  (d_vld),
        .quot     (d_quot),
        .side_out (d_side)
    );

    nppc_resp u_resp (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (d_vld),
        .quot    (d_quot),
        .side_in (d_side),
        .cfg     (cfg_reg),
        .vld_out (out_valid),
        .item    (out_item)
    );

endmodule
`default_nettype wire

// ===== rtl/core/nppc_norm.sv =====
`default_nettype none
module nppc_norm (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       vld_in,
    input  wire nppc_pkg::in_item_t         item,
    input  wire nppc_pkg::cfg_t             cfg,
    output logic                            vld_out,
    output logic [nppc_pkg::SQW-1:0]        sum_sq,
    output logic [2:0][nppc_pkg::AW-1:0]    a_out,
    output nppc_pkg::side_t                 side_out
);
    import nppc_pkg::*;

    logic signed [CW-1:0] mst [3];
    logic signed [CW-1:0] slv [3];
    logic signed [CW-1:0] mu [3];
    logic signed [CW-1:0] su [3];
    logic signed [CW-1:0] fix [3];

    logic [VW-1:0] mag_c [3];
    side_t         side_c;

    logic [VW-1:0]   mag1_reg [3];
    side_t           side1_reg;
    logic [VW-1:0]   mag2_reg [3];
    logic [1:0]      rsh2_reg;
    logic [4:0]      lsh2_reg;
    side_t           side2_reg;
    logic [AW-1:0]   a3_reg [3];
    side_t           side3_reg;
    logic [2*AW-1:0] sq4_reg [3];
    logic [AW-1:0]   a4_reg [3];
    side_t           side4_reg;
    logic [SQW-1:0]  sum5_reg;
    logic [AW-1:0]   a5_reg [3];
    side_t           side5_reg;
    logic [4:0]      vld_reg;

    logic [VW-1:0] mx;
    logic [5:0]    pos;
    logic [1:0]    rsh_c;
    logic [4:0]    lsh_c;

    assign mst = '{item.master_x, item.master_y, item.master_z};
    assign slv = '{item.slave_x, item.slave_y, item.slave_z};
    assign mu  = '{item.master_ux, item.master_uy, item.master_uz};
    assign su  = '{item.slave_ux, item.slave_uy, item.slave_uz};
    assign fix = '{cfg.fixed_normal_x, cfg.fixed_normal_y, cfg.fixed_normal_z};

    // raw normal magnitudes and deformed differences
    always_comb
    begin
        logic signed [VW:0] raw;
        logic signed [VW:0] mg;
        side_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.fixed_normal_enable)
                raw = (VW+1)'(fix[i]);
            else
                raw = (VW+1)'(slv[i]) - (VW+1)'(mst[i]);
            mg = raw[VW] ? -raw : raw;
            mag_c[i] = mg[VW-1:0];
            side_c.neg[2-i] = raw[VW];
            side_c.d[2-i] = (DW'(slv[i]) + DW'(su[i])) - (DW'(mst[i]) + DW'(mu[i]));
        end
        side_c.err = (mag_c[0] == '0) && (mag_c[1] == '0) && (mag_c[2] == '0);
    end

    // largest magnitude and its leading one
    always_comb
    begin
        mx = mag1_reg[0];
        if (mag1_reg[1] > mx)
            mx = mag1_reg[1];
        if (mag1_reg[2] > mx)
            mx = mag1_reg[2];
        pos = '0;
        for (int b = 0; b < VW; b++)
        begin
            if (mx[b])
                pos = 6'(b);
        end
        if (pos > 6'(AW - 1))
        begin
            rsh_c = 2'(pos - 6'(AW - 1));
            lsh_c = '0;
        end
        else
        begin
            rsh_c = '0;
            lsh_c = 5'(6'(AW - 1) - pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg  <= mag_c;
            side1_reg <= side_c;

            mag2_reg  <= mag1_reg;
            rsh2_reg  <= rsh_c;
            lsh2_reg  <= lsh_c;
            side2_reg <= side1_reg;

            for (int i = 0; i < 3; i++)
            begin
                if (rsh2_reg != '0)
                    a3_reg[i] <= AW'(mag2_reg[i] >> rsh2_reg);
                else
                    a3_reg[i] <= AW'(mag2_reg[i] << lsh2_reg);
            end
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= (2*AW)'(a3_reg[i]) * (2*AW)'(a3_reg[i]);
            a4_reg    <= a3_reg;
            side4_reg <= side3_reg;

            sum5_reg  <= SQW'(sq4_reg[0]) + SQW'(sq4_reg[1]) + SQW'(sq4_reg[2]);
            a5_reg    <= a4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign vld_out  = vld_reg[4];
    assign sum_sq   = sum5_reg;
    assign a_out    = {a5_reg[0], a5_reg[1], a5_reg[2]};
    assign side_out = side5_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nppc_sqrt.sv =====
`default_nettype none
module nppc_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       vld_in,
    input  wire logic [nppc_pkg::SQW-1:0]   sum_sq,
    input  wire logic [2:0][nppc_pkg::AW-1:0] a_in,
    input  wire nppc_pkg::side_t            side_in,
    output logic                            vld_out,
    output logic [nppc_pkg::LW-1:0]         root,
    output logic [2:0][nppc_pkg::AW-1:0]    a_out,
    output nppc_pkg::side_t                 side_out
);
    import nppc_pkg::*;

    logic [SQW-1:0]         rem_reg  [LW];
    logic [LW-1:0]          root_reg [LW];
    logic [2:0][AW-1:0]     a_reg    [LW];
    side_t                  side_reg [LW];
    logic [LW-1:0]          vld_reg;

    // one root bit per stage, most significant first
    for (genvar s = 0; s < LW; s++)
    begin : g_stage
        localparam int K = LW - 1 - s;
        logic [SQW-1:0]     rem_in;
        logic [LW-1:0]      root_in;
        logic [2:0][AW-1:0] a_st;
        side_t              side_st;
        logic               vld_st;
        logic [SQW+1:0]     trial;
        logic               fits;

        if (s == 0)
        begin : g_src
            assign rem_in  = sum_sq;
            assign root_in = '0;
            assign a_st    = a_in;
            assign side_st = side_in;
            assign vld_st  = vld_in;
        end
        else
        begin : g_src
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign a_st    = a_reg[s-1];
            assign side_st = side_reg[s-1];
            assign vld_st  = vld_reg[s-1];
        end

        assign trial = ((SQW+2)'(root_in) << (K + 1)) + ((SQW+2)'(1) << (2 * K));
        assign fits  = (SQW+2)'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_st;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= fits ? (rem_in - trial[SQW-1:0]) : rem_in;
                root_reg[s] <= fits ? (root_in | (LW'(1) << K)) : root_in;
                a_reg[s]    <= a_st;
                side_reg[s] <= side_st;
            end
        end
    end

    assign vld_out  = vld_reg[LW-1];
    assign root     = root_reg[LW-1];
    assign a_out    = a_reg[LW-1];
    assign side_out = side_reg[LW-1];

endmodule
`default_nettype wire

// ===== rtl/core/nppc_div.sv =====
`default_nettype none
module nppc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       vld_in,
    input  wire logic [nppc_pkg::LW-1:0]    root,
    input  wire logic [2:0][nppc_pkg::AW-1:0] a_in,
    input  wire nppc_pkg::side_t            side_in,
    output logic                            vld_out,
    output logic [2:0][nppc_pkg::QW-1:0]    quot,
    output nppc_pkg::side_t                 side_out
);
    import nppc_pkg::*;

    logic [2:0][DVW-1:0] rem_reg  [QW];
    logic [2:0][QW-1:0]  q_reg    [QW];
    logic [LW-1:0]       den_reg  [QW];
    side_t               side_reg [QW];
    logic [QW-1:0]       vld_reg;

    // one quotient bit per stage for all three lanes
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int K = QW - 1 - s;
        logic [2:0][DVW-1:0] rem_in;
        logic [2:0][QW-1:0]  q_in;
        logic [LW-1:0]       den_in;
        side_t               side_st;
        logic                vld_st;
        logic [DVW-1:0]      dsh;

        if (s == 0)
        begin : g_src
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = (DVW'(a_in[i]) << NormBits) + DVW'(root >> 1);
            end
            assign q_in    = '0;
            assign den_in  = root;
            assign side_st = side_in;
            assign vld_st  = vld_in;
        end
        else
        begin : g_src
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_st = side_reg[s-1];
            assign vld_st  = vld_reg[s-1];
        end

        assign dsh = DVW'(den_in) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_st;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_in[i] >= dsh)
                    begin
                        rem_reg[s][i] <= rem_in[i] - dsh;
                        q_reg[s][i]   <= q_in[i] | (QW'(1) << K);
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_in[i];
                        q_reg[s][i]   <= q_in[i];
                    end
                end
                den_reg[s]  <= den_in;
                side_reg[s] <= side_st;
            end
        end
    end

    assign vld_out  = vld_reg[QW-1];
    assign quot     = q_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
`default_nettype wire

// ===== rtl/core/nppc_resp.sv =====
`default_nettype none
module nppc_resp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       vld_in,
    input  wire logic [2:0][nppc_pkg::QW-1:0] quot,
    input  wire nppc_pkg::side_t            side_in,
    input  wire nppc_pkg::cfg_t             cfg,
    output logic                            vld_out,
    output nppc_pkg::out_item_t             item
);
    import nppc_pkg::*;

    localparam int PDW = DW + NW;
    localparam int NNW = 2 * NW;
    localparam int GNW = GW + NW;
    localparam int GRW = GNW - NormBits;
    localparam int PQW = PW + 1 + NW;
    localparam int PGW = PW + 1 + GRW;

    logic signed [PW:0]     pen;

    logic signed [NW-1:0]   n1_reg [3];
    logic signed [DW-1:0]   d1_reg [3];
    logic                   err1_reg;

    logic signed [PDW-1:0]  p2_reg [3];
    logic signed [NNW-1:0]  nn2_reg [6];
    logic signed [NW-1:0]   n2_reg [3];
    logic                   err2_reg;

    logic signed [GW-1:0]   gap3_reg;
    logic signed [NW-1:0]   q3_reg [6];
    logic signed [NW-1:0]   n3_reg [3];
    logic                   err3_reg;

    logic signed [GNW-1:0]  gn4_reg [3];
    logic signed [PQW-1:0]  pq4_reg [6];
    logic signed [GW-1:0]   gap4_reg;
    logic                   err4_reg;

    logic signed [GRW-1:0]  g5_reg [3];
    logic signed [OW-1:0]   k5_reg [6];
    logic signed [GW-1:0]   gap5_reg;
    logic                   err5_reg;

    logic signed [PGW-1:0]  pg6_reg [3];
    logic signed [OW-1:0]   k6_reg [6];
    logic signed [GW-1:0]   gap6_reg;
    logic                   err6_reg;

    out_item_t              out_reg;
    logic [6:0]             vld_reg;

    logic signed [OW-1:0]   f_c [3];
    logic signed [OW-1:0]   k_c [6];
    logic signed [XW-1:0]   acc;
    out_item_t              out_next;

    assign pen = $signed({1'b0, cfg.penalty});

    always_comb
    begin
        acc = XW'(p2_reg[0] >>> 2) + XW'(p2_reg[1] >>> 2) + XW'(p2_reg[2] >>> 2);
    end

    // final rounding, open or error masking, and tangent enable masking
    always_comb
    begin
        logic closed;
        logic stiff_on;
        closed   = gap6_reg < 0;
        stiff_on = cfg.tangent_enable && (gap6_reg <= 0);
        for (int i = 0; i < 3; i++)
            f_c[i] = closed ? sat_ow(rnd_shr(XW'(pg6_reg[i]), FracBits)) : '0;
        for (int j = 0; j < 6; j++)
            k_c[j] = stiff_on ? k6_reg[j] : '0;
        out_next = '0;
        if (err6_reg)
            out_next.normal_error = 1'b1;
        else
        begin
            out_next.force_x  = f_c[0];
            out_next.force_y  = f_c[1];
            out_next.force_z  = f_c[2];
            out_next.stiff_xx = k_c[0];
            out_next.stiff_xy = k_c[1];
            out_next.stiff_xz = k_c[2];
            out_next.stiff_yy = k_c[3];
            out_next.stiff_yz = k_c[4];
            out_next.stiff_zz = k_c[5];
            out_next.gap      = gap6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[5:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // signed unit normal
            for (int i = 0; i < 3; i++)
            begin
                if (side_in.neg[2-i])
                    n1_reg[i] <= -$signed({1'b0, quot[2-i]});
                else
                    n1_reg[i] <= $signed({1'b0, quot[2-i]});
                d1_reg[i] <= $signed(side_in.d[2-i]);
            end
            err1_reg <= side_in.err;

            // gap terms and normal outer products
            for (int i = 0; i < 3; i++)
                p2_reg[i] <= PDW'(d1_reg[i]) * PDW'(n1_reg[i]);
            for (int j = 0; j < 6; j++)
                nn2_reg[j] <= NNW'(n1_reg[PairI[j]]) * NNW'(n1_reg[PairJ[j]]);
            n2_reg   <= n1_reg;
            err2_reg <= err1_reg;

            gap3_reg <= sat_gw(rnd_shr(acc, NormBits - 2));
            for (int j = 0; j < 6; j++)
                q3_reg[j] <= NW'(rnd_shr(XW'(nn2_reg[j]), NormBits));
            n3_reg   <= n2_reg;
            err3_reg <= err2_reg;

            for (int i = 0; i < 3; i++)
                gn4_reg[i] <= GNW'(gap3_reg) * GNW'(n3_reg[i]);
            for (int j = 0; j < 6; j++)
                pq4_reg[j] <= PQW'(pen) * PQW'(q3_reg[j]);
            gap4_reg <= gap3_reg;
            err4_reg <= err3_reg;

            for (int i = 0; i < 3; i++)
                g5_reg[i] <= GRW'(rnd_shr(XW'(gn4_reg[i]), NormBits));
            for (int j = 0; j < 6; j++)
                k5_reg[j] <= sat_ow(rnd_shr(XW'(pq4_reg[j]), NormBits));
            gap5_reg <= gap4_reg;
            err5_reg <= err4_reg;

            for (int i = 0; i < 3; i++)
                pg6_reg[i] <= PGW'(pen) * PGW'(g5_reg[i]);
            k6_reg   <= k5_reg;
            gap6_reg <= gap5_reg;
            err6_reg <= err5_reg;

            out_reg <= out_next;
        end
    end

    assign vld_out = vld_reg[6];
    assign item    = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nppc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module nppc_checker (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire nppc_pkg::out_item_t     out_item
);
    import nppc_pkg::*;

    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
    `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item), "stalled result changed")
    `CHK_NOW(a_in_stall_src, in_valid && in_stall, out_valid && out_stall, "input stalled without cause")
    `CHK_NOW(a_err_zero, out_valid && out_item.normal_error, out_item.gap == 0 && out_item.force_x == 0 && out_item.stiff_xx == 0 && out_item.stiff_zz == 0, "error item not zeroed")
    `CHK_NOW(a_open_zero, out_valid && out_item.gap > 0, out_item.force_x == 0 && out_item.force_y == 0 && out_item.force_z == 0 && out_item.stiff_yy == 0, "open contact carries load")

endmodule

bind node_pair_penalty_contact_core nppc_checker u_nppc_checker (.*);
`default_nettype wire
